FILE: src/ffsd_pkg.sv
package ffsd_pkg;

  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_VERSION = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_OFFSET  = 5'b01000,
    PH_DATA    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_DROP   = 2'd2
  } kind_t;

  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] VERSION_RESET = 8'h01;
  localparam logic [7:0] MIN_LENGTH    = 8'd5;
  localparam logic [7:0] MAX_PAYLOAD   = 8'd250;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] payload_len;
  } result_t;

endpackage

FILE: src/ffsd_in_reg.sv
module ffsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_byte;
    end
  end

endmodule

FILE: src/ffsd_decode.sv
module ffsd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              step,
  input  logic [7:0]        stage_byte,
  output ffsd_pkg::result_t res
);
  import ffsd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] expected_version;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] next_stuff_position, next_stuff_position_next;
  logic [7:0] running_sum, running_sum_next;

  logic [7:0] pos_inc;
  logic [7:0] room;
  logic       stuffed;
  logic [7:0] decoded;
  logic       last_byte;

  assign pos_inc   = byte_position + 8'd1;
  assign room      = frame_length - pos_inc;
  assign stuffed   = (pos_inc == next_stuff_position);
  assign decoded   = stuffed ? START_BYTE : stage_byte;
  assign last_byte = ({1'b0, pos_inc} + 9'd1) == {1'b0, frame_length};

  always_comb begin
    phase_next               = phase;
    byte_position_next       = byte_position;
    frame_length_next        = frame_length;
    next_stuff_position_next = next_stuff_position;
    running_sum_next         = running_sum;
    res                      = '0;
    res.kind                 = KIND_DATA;

    if (stage_byte == START_BYTE) begin
      // restart; an open frame is dropped
      res.valid                = (phase != PH_WAIT);
      res.kind                 = KIND_DROP;
      phase_next               = PH_VERSION;
      byte_position_next       = '0;
      frame_length_next        = '0;
      next_stuff_position_next = '0;
      running_sum_next         = START_BYTE;
    end else begin
      unique case (phase)
        PH_VERSION: begin
          byte_position_next = pos_inc;
          running_sum_next   = running_sum + stage_byte;
          if (stage_byte != expected_version) begin
            res.valid         = 1'b1;
            res.kind          = KIND_DROP;
            phase_next        = PH_WAIT;
            frame_length_next = '0;
          end else begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          byte_position_next = pos_inc;
          running_sum_next   = running_sum + stage_byte;
          if (stage_byte < MIN_LENGTH) begin
            res.valid         = 1'b1;
            res.kind          = KIND_DROP;
            phase_next        = PH_WAIT;
            frame_length_next = '0;
          end else begin
            frame_length_next = stage_byte;
            phase_next        = PH_OFFSET;
          end
        end
        PH_OFFSET: begin
          byte_position_next = pos_inc;
          if (stage_byte > room) begin
            res.valid         = 1'b1;
            res.kind          = KIND_DROP;
            phase_next        = PH_WAIT;
            frame_length_next = '0;
          end else begin
            next_stuff_position_next = stage_byte + pos_inc;
            phase_next               = PH_DATA;
          end
        end
        PH_DATA: begin
          byte_position_next = pos_inc;
          if (stuffed && (stage_byte > room)) begin
            res.valid         = 1'b1;
            res.kind          = KIND_DROP;
            phase_next        = PH_WAIT;
            frame_length_next = '0;
          end else begin
            if (stuffed) begin
              next_stuff_position_next = stage_byte + pos_inc;
            end
            if (last_byte) begin
              phase_next        = PH_WAIT;
              frame_length_next = '0;
              res.valid         = 1'b1;
              if (running_sum != decoded) begin
                res.kind = KIND_DROP;
              end else begin
                res.kind        = KIND_ACCEPT;
                res.payload_len = frame_length - MIN_LENGTH;
              end
            end else begin
              running_sum_next = running_sum + decoded;
              res.valid        = 1'b1;
              res.kind         = KIND_DATA;
              res.data         = decoded;
            end
          end
        end
        default: begin
          phase_next = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
    end else if (cfg_wr_en) begin
      expected_version <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_WAIT;
      byte_position       <= '0;
      frame_length        <= '0;
      next_stuff_position <= '0;
      running_sum         <= '0;
    end else if (step) begin
      phase               <= phase_next;
      byte_position       <= byte_position_next;
      frame_length        <= frame_length_next;
      next_stuff_position <= next_stuff_position_next;
      running_sum         <= running_sum_next;
    end
  end

endmodule

FILE: src/ffsd_out_reg.sv
module ffsd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ffsd_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_data,
  output logic [7:0]        out_payload_len
);
  import ffsd_pkg::*;

  kind_t kind;

  assign free     = !out_valid || out_ready;
  assign out_kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      kind            <= res.kind;
      out_data        <= res.data;
      out_payload_len <= res.payload_len;
    end
  end

endmodule

FILE: src/ff_stuffed_frame_decoder_core.sv
// Byte-stuffed frame decoder. Takes one received byte per transaction and
// emits decoded payload bytes followed by one accept or drop mark per frame;
// bytes outside a frame produce nothing. Throughput is one byte per clock
// unless the output stalls: an input register feeds a combinational decode
// step that updates the frame state and loads a result register. While a
// result waits unaccepted, the input register takes one more byte and then
// holds the input off until the result register is emptied. Write
// expected_version only while idle.
module ff_stuffed_frame_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic [7:0] out_payload_len
);
  import ffsd_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       free;
  logic       advance;
  result_t    res;

  assign advance = stage_valid && free;

  ffsd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  ffsd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .stage_byte  (stage_byte),
    .res         (res)
  );

  ffsd_out_reg u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .load            (advance),
    .res             (res),
    .free            (free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data        (out_data),
    .out_payload_len (out_payload_len)
  );

endmodule

FILE: src/ffsd_checker.sv
module ffsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data,
  input logic [7:0] out_payload_len
);
  import ffsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data)
      && $stable(out_payload_len))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_ACCEPT
      || out_kind == KIND_DROP))
    else $error("unknown result kind");

  a_mark_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DATA |-> out_data == 8'd0
      && (out_kind == KIND_ACCEPT || out_payload_len == 8'd0))
    else $error("frame mark carries data");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ACCEPT |-> out_payload_len <= MAX_PAYLOAD)
    else $error("payload length out of range");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2) && !$past(out_valid)
      |-> !out_valid)
    else $error("result without input");

endmodule

bind ff_stuffed_frame_decoder_core ffsd_checker u_ffsd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_data        (out_data),
  .out_payload_len (out_payload_len)
);
